>>> hw/rtl/tllc_pkg.sv
// shared types and constants for the two-level lru cache timing core
// no dependencies; used by the top level
`default_nettype none

package tllc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned LatW     = 13;

  localparam logic [CfgIdxW-1:0] CFG_ICACHE_HIT_LAT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DCACHE_HIT_LAT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_L2_HIT_LAT     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MEMORY_LAT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LINE_OFFSET    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ICACHE_EN      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DCACHE_EN      = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_L2_EN          = 3'd7;

  typedef struct packed {
    logic            l2_hit;
    logic            l2_accessed;
    logic            l1_hit;
    logic [LatW-1:0] latency;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/two_level_lru_cache_timing_core.sv
// top level of the two-level lru cache timing core: config registers, sequencer, output stage
// depends on tllc_pkg and tllc_level
//
// usage:
//   input stream: s_tdata carries the byte address, s_tuser the port
//   (0 instruction, 1 data). one transaction in gives one transaction out.
//   output stream: m_tdata = {l2_hit, l2_accessed, l1_hit, latency[12:0]}.
//   config channel: cfg_index picks the register, cfg_data the value; write
//   only while no access is in flight.
// timing:
//   the result is formed in state S_L1 (l1 hit, disabled l1 or l2) or in S_L2
//   (l2 lookup) and then registered; the next input is accepted once the sequencer
//   is back in S_IDLE, as each level's set memory has a registered read.
// reset:
//   every level sweeps its set memory, one set per cycle, to clear valid bits
//   and restore ranks; no access is accepted until the longest sweep ends
//   (the l2 sweep with default sizes).
// backpressure:
//   a result waiting on m_tready sits in the output register; one more result
//   can park in a holding register, after which s_tready drops.
`default_nettype none

module two_level_lru_cache_timing_core #(
  parameter int unsigned I_SETS  = 256,
  parameter int unsigned I_WAYS  = 2,
  parameter int unsigned D_SETS  = 256,
  parameter int unsigned D_WAYS  = 2,
  parameter int unsigned L2_SETS = 1024,
  parameter int unsigned L2_WAYS = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [31:0]                  s_tdata,   // address[31:0]
  input  wire                          s_tuser,   // port
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [15:0]                  m_tdata,   // latency[12:0], l1_hit, l2_accessed, l2_hit
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [tllc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire  [tllc_pkg::CfgDataW-1:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_L1, S_L2} state_t;

  state_t state;

  logic [7:0]  icache_hit_latency;
  logic [7:0]  dcache_hit_latency;
  logic [7:0]  l2_hit_latency;
  logic [11:0] memory_latency;
  logic [3:0]  line_offset_bits;
  logic        icache_enabled;
  logic        dcache_enabled;
  logic        l2_enabled;

  logic        port_q;
  logic        en_q;
  logic [31:0] addr_q;

  logic i_busy, d_busy, l2_busy;
  logic i_hit, d_hit, l2_hit;
  logic i_req, d_req, l2_req;
  logic accept;
  logic out_free;

  logic               res_fire;
  tllc_pkg::result_t  res;
  tllc_pkg::result_t  pend;
  logic               pend_valid;
  logic [tllc_pkg::LatW-1:0] hit_time;
  logic               l1_hit;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE) && !pend_valid && !i_busy && !d_busy && !l2_busy;
  assign accept    = s_tvalid && s_tready;
  assign i_req     = accept && !s_tuser && icache_enabled;
  assign d_req     = accept && s_tuser && dcache_enabled;
  assign out_free  = !m_tvalid || m_tready;

  assign hit_time = port_q ? tllc_pkg::LatW'(dcache_hit_latency)
                           : tllc_pkg::LatW'(icache_hit_latency);
  assign l1_hit   = port_q ? d_hit : i_hit;

  tllc_level #(.SETS(I_SETS), .WAYS(I_WAYS)) u_il1 (
    .clk(clk), .rst(rst), .req(i_req), .addr(s_tdata), .off(line_offset_bits),
    .busy(i_busy), .hit(i_hit)
  );

  tllc_level #(.SETS(D_SETS), .WAYS(D_WAYS)) u_dl1 (
    .clk(clk), .rst(rst), .req(d_req), .addr(s_tdata), .off(line_offset_bits),
    .busy(d_busy), .hit(d_hit)
  );

  tllc_level #(.SETS(L2_SETS), .WAYS(L2_WAYS)) u_l2 (
    .clk(clk), .rst(rst), .req(l2_req), .addr(addr_q), .off(line_offset_bits),
    .busy(l2_busy), .hit(l2_hit)
  );

  always_comb begin
    res_fire        = 1'b0;
    l2_req          = 1'b0;
    res.latency     = '0;
    res.l1_hit      = 1'b0;
    res.l2_accessed = 1'b0;
    res.l2_hit      = 1'b0;
    case (state)
      S_L1: begin
        if (!en_q) begin
          res_fire    = 1'b1;
          res.latency = tllc_pkg::LatW'(memory_latency);
        end else if (l1_hit) begin
          res_fire    = 1'b1;
          res.l1_hit  = 1'b1;
          res.latency = hit_time;
        end else if (!l2_enabled) begin
          res_fire    = 1'b1;
          res.latency = hit_time + tllc_pkg::LatW'(memory_latency);
        end else begin
          l2_req = 1'b1;
        end
      end
      S_L2: begin
        res_fire        = 1'b1;
        res.l2_accessed = 1'b1;
        res.l2_hit      = l2_hit;
        res.latency     = hit_time + tllc_pkg::LatW'(l2_hit_latency)
                        + (l2_hit ? '0 : tllc_pkg::LatW'(memory_latency));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (accept) state <= S_L1;
        S_L1:   if (!l2_req) state <= S_IDLE; else state <= S_L2;
        S_L2:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
    if (accept) begin
      port_q <= s_tuser;
      en_q   <= s_tuser ? dcache_enabled : icache_enabled;
      addr_q <= s_tdata;
    end
  end

  // output register with one holding slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (pend_valid) begin
          m_tvalid   <= 1'b1;
          m_tdata    <= pend;
          pend_valid <= 1'b0;
        end else if (res_fire) begin
          m_tvalid <= 1'b1;
          m_tdata  <= res;
        end else begin
          m_tvalid <= 1'b0;
        end
      end else if (res_fire) begin
        pend_valid <= 1'b1;
        pend       <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      icache_hit_latency <= 8'd1;
      dcache_hit_latency <= 8'd1;
      l2_hit_latency     <= 8'd10;
      memory_latency     <= 12'd100;
      line_offset_bits   <= 4'd6;
      icache_enabled     <= 1'b1;
      dcache_enabled     <= 1'b1;
      l2_enabled         <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tllc_pkg::CFG_ICACHE_HIT_LAT: icache_hit_latency <= cfg_data[7:0];
        tllc_pkg::CFG_DCACHE_HIT_LAT: dcache_hit_latency <= cfg_data[7:0];
        tllc_pkg::CFG_L2_HIT_LAT:     l2_hit_latency     <= cfg_data[7:0];
        tllc_pkg::CFG_MEMORY_LAT:     memory_latency     <= cfg_data;
        tllc_pkg::CFG_LINE_OFFSET:    line_offset_bits   <= cfg_data[3:0];
        tllc_pkg::CFG_ICACHE_EN:      icache_enabled     <= cfg_data[0];
        tllc_pkg::CFG_DCACHE_EN:      dcache_enabled     <= cfg_data[0];
        tllc_pkg::CFG_L2_EN:          l2_enabled         <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tllc_level.sv
// one set-associative level with true lru: tag, valid and rank rows in one memory
// one row per set; read one cycle after req, compare and write back in the next
// depends on nothing but its parameters
`default_nettype none

module tllc_level #(
  parameter int unsigned SETS = 256,
  parameter int unsigned WAYS = 2
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        req,
  input  wire [31:0] addr,
  input  wire [3:0]  off,
  output logic       busy,
  output logic       hit
);

  localparam int unsigned IdxW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned Fl   = $clog2(SETS + 1) - 1;
  localparam int unsigned TagW = 32 - Fl;
  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [IdxW-1:0] IdxMask = IdxW'(SETS - 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(SETS - 1);

  typedef struct packed {
    logic [WAYS-1:0][TagW-1:0] tag;
    logic [WAYS-1:0]           vld;
    logic [WAYS-1:0][WayW-1:0] rank;
  } row_t;

  row_t mem [SETS];

  logic [IdxW-1:0] clr_idx;
  logic            chk;
  logic [IdxW-1:0] idx_q;
  logic [TagW-1:0] tag_q;
  row_t            rd_row;

  logic [31:0]     idx_sh;
  logic [31:0]     tag_sh;
  logic [IdxW-1:0] idx_in;
  logic [4:0]      tag_shamt;

  logic [WAYS-1:0] way_hit;
  logic [WayW-1:0] hit_way;
  logic [WayW-1:0] inv_way;
  logic [WayW-1:0] lru_way;
  logic            any_inv;
  logic            found_inv;
  logic            found_lru;
  logic [WayW-1:0] sel_way;
  logic [WayW-1:0] old_rank;
  row_t            wr_row;
  row_t            clr_row;

  assign idx_sh    = addr >> off;
  assign idx_in    = idx_sh[IdxW-1:0] & IdxMask;
  assign tag_shamt = 5'(off) + 5'(Fl);
  assign tag_sh    = addr >> tag_shamt;

  // hit search and victim choice, lowest way first
  always_comb begin
    hit_way   = '0;
    inv_way   = '0;
    lru_way   = '0;
    found_inv = 1'b0;
    found_lru = 1'b0;
    hit       = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      way_hit[i] = rd_row.vld[i] && (rd_row.tag[i] == tag_q);
      if (way_hit[i] && !hit) begin
        hit     = 1'b1;
        hit_way = WayW'(i);
      end
      if (!rd_row.vld[i] && !found_inv) begin
        found_inv = 1'b1;
        inv_way   = WayW'(i);
      end
      if (rd_row.rank[i] == '0 && !found_lru) begin
        found_lru = 1'b1;
        lru_way   = WayW'(i);
      end
    end
    any_inv = found_inv;
    if (hit)          sel_way = hit_way;
    else if (any_inv) sel_way = inv_way;
    else              sel_way = lru_way;
    old_rank = rd_row.rank[sel_way];
    wr_row   = rd_row;
    for (int i = 0; i < WAYS; i++) begin
      if (WayW'(i) == sel_way) begin
        wr_row.rank[i] = WayW'(WAYS - 1);
        wr_row.vld[i]  = 1'b1;
        wr_row.tag[i]  = tag_q;
      end else if (rd_row.rank[i] > old_rank) begin
        wr_row.rank[i] = rd_row.rank[i] - 1'b1;
      end
    end
    clr_row = rd_row;
    for (int i = 0; i < WAYS; i++) begin
      clr_row.vld[i]  = 1'b0;
      clr_row.rank[i] = WayW'(i);
    end
  end

  // clearing pass after reset, one set per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
      chk     <= 1'b0;
    end else begin
      chk <= req;
      if (busy) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == IdxLast) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= clr_row;
    end else if (chk) begin
      mem[idx_q] <= wr_row;
    end
    if (req) begin
      rd_row <= mem[idx_in];
      idx_q  <= idx_in;
      tag_q  <= tag_sh[TagW-1:0];
    end
  end

endmodule

`default_nettype wire
